/* rtl/core/mlfq_pkg.sv */
`default_nettype none
package mlfq_pkg;
   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_ENQ  = 2'd1,
      FUNC_DEQ  = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOOST_RD,
      ST_BOOST_WR,
      ST_OP,
      ST_DEQ_WAIT,
      ST_RESP
   } state_type;

   localparam logic [15:0] BOOST_RESET = 16'd1000;
endpackage
`default_nettype wire

/* rtl/core/mlfq_store.sv */
`default_nettype none
// Task id memory: one write port, one registered read port.
module mlfq_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/multilevel_feedback_queue_scheduler_core.sv */
`default_nettype none
// Multilevel feedback queue scheduler. Each request word is a tick, an enqueue,
// a dequeue or a no-op and yields exactly one response word. Task ids live in
// one synchronous memory of NUM_LEVELS rings of CAPACITY entries; head, tail and
// count per level sit in flops. A tick or an enqueue goes from accept through
// OP and RESP to response valid; a dequeue adds DEQ_WAIT (one memory read).
// When a boost is due, the walk moves every task of levels 1 and up to level 0
// through OP, BOOST_RD and BOOST_WR per task (address the popped entry, read it
// back, write it to level 0). The response register frees the request side as
// soon as the response word is taken; a new request word is not taken while an
// earlier response word waits. No clearing pass after reset.
module multilevel_feedback_queue_scheduler_core #(
   parameter int NUM_LEVELS = 8,
   parameter int CAPACITY   = 64,
   parameter int ID_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0]  req_task_level,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_task_id,
   output logic [4:0]       rsp_out_level,
   output logic             rsp_boosted,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_boost_interval
);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = LW + PW;
   localparam int IW = (ID_WIDTH < 16) ? ID_WIDTH : 16;

   // boost interval register
   logic [15:0] interval_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) interval_ff <= mlfq_pkg::BOOST_RESET;
      else if (csr_valid) interval_ff <= csr_boost_interval;
   end

   mlfq_pkg::state_type state_ff, state_in;

   logic [PW-1:0] head_ff [NUM_LEVELS];
   logic [PW-1:0] tail_ff [NUM_LEVELS];
   logic [CW-1:0] cnt_ff  [NUM_LEVELS];
   logic [CW-1:0] total_ff;
   logic [15:0]   ticks_ff;

   // latched request word
   logic [1:0]    func_ff;
   logic [IW-1:0] id_ff;
   logic [LW-1:0] lvl_ff;
   logic          boost_ff;
   logic [LW-1:0] blvl_ff;   // level being drained
   logic [LW-1:0] dlvl_ff;   // dequeue level

   // response register
   logic        rvalid_ff;
   logic [1:0]  rstat_ff;
   logic [15:0] rid_ff;
   logic [4:0]  rlvl_ff;
   logic        rboost_ff;

   // memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [IW-1:0] wr_data, rd_data;

   // address is {level, slot}, so the memory spans the full address range
   mlfq_store #(.DEPTH(1 << AW), .AW(AW), .DW(IW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
      logic [PW:0] s;
      s = {1'b0, p} + 1'b1;
      if (s == (PW+1)'(CAPACITY)) s = '0;
      return s[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
      return (p == '0) ? PW'(CAPACITY - 1) : p - 1'b1;
   endfunction

   // first nonempty level (dequeue) and first nonempty level >= 1 (boost)
   logic [LW-1:0] first_lvl, boost_lvl;
   logic          any_lvl, any_boost;
   always_comb begin
      first_lvl = '0; any_lvl = 1'b0;
      boost_lvl = '0; any_boost = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            first_lvl = LW'(i); any_lvl = 1'b1;
            if (i != 0) begin
               boost_lvl = LW'(i); any_boost = 1'b1;
            end
         end
      end
   end

   // requested level modulo NUM_LEVELS, as a constant lookup over all 256 codes
   logic [LW-1:0] req_lvl;
   always_comb begin
      req_lvl = '0;
      for (int v = 0; v < 256; v++) begin
         if (req_task_level == 8'(v)) req_lvl = LW'(v % NUM_LEVELS);
      end
   end

   assign req_ready = (state_ff == mlfq_pkg::ST_IDLE) && (!rvalid_ff || rsp_ready);
   logic accept;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      wr_en = 1'b0;
      wr_addr = {lvl_ff, tail_ff[lvl_ff]};
      wr_data = id_ff;
      rd_addr = {blvl_ff, ring_dec(tail_ff[blvl_ff])};
      unique case (state_ff)
         mlfq_pkg::ST_IDLE: begin
            if (accept) state_in = mlfq_pkg::ST_OP;
         end
         mlfq_pkg::ST_BOOST_RD: begin
            // tail already stepped back: it now points at the popped entry
            rd_addr = {blvl_ff, tail_ff[blvl_ff]};
            state_in = mlfq_pkg::ST_BOOST_WR;
         end
         mlfq_pkg::ST_BOOST_WR: begin
            wr_en = 1'b1;
            wr_addr = {LW'(0), tail_ff[0]};
            wr_data = rd_data;
            state_in = mlfq_pkg::ST_OP;
         end
         mlfq_pkg::ST_OP: begin
            if (boost_ff && any_boost) begin
               state_in = mlfq_pkg::ST_BOOST_RD;
               rd_addr = {boost_lvl, ring_dec(tail_ff[boost_lvl])};
            end else if (func_ff == mlfq_pkg::FUNC_DEQ && any_lvl) begin
               rd_addr = {first_lvl, head_ff[first_lvl]};
               state_in = mlfq_pkg::ST_DEQ_WAIT;
            end else begin
               wr_en = (func_ff == mlfq_pkg::FUNC_ENQ)
                       && (total_ff != CW'(CAPACITY));
               wr_addr = {boost_ff ? LW'(0) : lvl_ff,
                          tail_ff[boost_ff ? LW'(0) : lvl_ff]};
               state_in = mlfq_pkg::ST_RESP;
            end
         end
         mlfq_pkg::ST_DEQ_WAIT: state_in = mlfq_pkg::ST_RESP;
         mlfq_pkg::ST_RESP: state_in = mlfq_pkg::ST_IDLE;
         default: state_in = mlfq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mlfq_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   logic [LW-1:0] enq_lvl;
   assign enq_lvl = boost_ff ? LW'(0) : lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0; tail_ff[i] <= '0; cnt_ff[i] <= '0;
         end
         total_ff <= '0;
         ticks_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         // response word is raised from RESP and held until taken
         if (state_ff == mlfq_pkg::ST_RESP) rvalid_ff <= 1'b1;
         else if (rsp_ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            mlfq_pkg::ST_IDLE: begin
               if (accept) begin
                  func_ff <= req_func;
                  id_ff <= req_task_id[IW-1:0];
                  lvl_ff <= req_lvl;
                  boost_ff <= (req_func == mlfq_pkg::FUNC_ENQ
                               || req_func == mlfq_pkg::FUNC_DEQ)
                              && (ticks_ff >= interval_ff);
                  if (req_func == mlfq_pkg::FUNC_TICK) begin
                     if (ticks_ff >= interval_ff) ticks_ff <= interval_ff;
                     else ticks_ff <= ticks_ff + 16'd1;
                  end else if ((req_func == mlfq_pkg::FUNC_ENQ
                                || req_func == mlfq_pkg::FUNC_DEQ)
                               && (ticks_ff >= interval_ff)) begin
                     ticks_ff <= '0;
                  end
               end
            end
            mlfq_pkg::ST_BOOST_RD: ;
            mlfq_pkg::ST_BOOST_WR: begin
               tail_ff[0] <= ring_inc(tail_ff[0]);
               cnt_ff[0] <= cnt_ff[0] + 1'b1;
            end
            mlfq_pkg::ST_OP: begin
               if (boost_ff && any_boost) begin
                  blvl_ff <= boost_lvl;
                  tail_ff[boost_lvl] <= ring_dec(tail_ff[boost_lvl]);
                  cnt_ff[boost_lvl] <= cnt_ff[boost_lvl] - 1'b1;
               end else if (func_ff == mlfq_pkg::FUNC_DEQ && any_lvl) begin
                  dlvl_ff <= first_lvl;
                  head_ff[first_lvl] <= ring_inc(head_ff[first_lvl]);
                  cnt_ff[first_lvl] <= cnt_ff[first_lvl] - 1'b1;
                  total_ff <= total_ff - 1'b1;
               end else begin
                  rstat_ff <= mlfq_pkg::STATUS_OK;
                  rid_ff <= '0;
                  rlvl_ff <= '0;
                  rboost_ff <= boost_ff;
                  if (func_ff == mlfq_pkg::FUNC_ENQ) begin
                     if (total_ff == CW'(CAPACITY)) begin
                        rstat_ff <= mlfq_pkg::STATUS_FULL;
                     end else begin
                        tail_ff[enq_lvl] <= ring_inc(tail_ff[enq_lvl]);
                        cnt_ff[enq_lvl] <= cnt_ff[enq_lvl] + 1'b1;
                        total_ff <= total_ff + 1'b1;
                     end
                  end else if (func_ff == mlfq_pkg::FUNC_DEQ) begin
                     rstat_ff <= mlfq_pkg::STATUS_EMPTY;
                  end
               end
            end
            mlfq_pkg::ST_DEQ_WAIT: begin
               rstat_ff <= mlfq_pkg::STATUS_OK;
               rid_ff <= 16'(rd_data);
               rlvl_ff <= 5'(dlvl_ff) + 5'd1;
               rboost_ff <= boost_ff;
            end
            mlfq_pkg::ST_RESP: ;
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_status      = rstat_ff;
   assign rsp_out_task_id = rid_ff;
   assign rsp_out_level   = rlvl_ff;
   assign rsp_boosted     = rboost_ff;
endmodule
`default_nettype wire
